FILE: rtl/mipsdec_pkg.sv
package mipsdec_pkg;

  typedef enum logic [2:0] {
    CLS_NONE   = 3'd0,
    CLS_ALU    = 3'd1,
    CLS_BRANCH = 3'd2,
    CLS_JUMP   = 3'd3,
    CLS_LOAD   = 3'd4,
    CLS_STORE  = 3'd5,
    CLS_SYSTEM = 3'd6
  } iclass_t;

  typedef enum logic [2:0] {
    MW_NONE  = 3'd0,
    MW_BYTE  = 3'd1,
    MW_HALF  = 3'd2,
    MW_WORD  = 3'd3,
    MW_DWORD = 3'd4,
    MW_QWORD = 3'd5
  } mwidth_t;

  // Identity codes that the logic tests by name
  localparam logic [6:0] ID_UNKNOWN = 7'd0;
  localparam logic [6:0] ID_NOP     = 7'd1;
  localparam logic [6:0] ID_JR      = 7'd8;
  localparam logic [6:0] ID_JALR    = 7'd9;
  localparam logic [6:0] ID_MTHI1   = 7'd17;
  localparam logic [6:0] ID_MTLO1   = 7'd18;
  localparam logic [6:0] ID_MTSAH   = 7'd19;
  localparam logic [6:0] ID_PADDUW  = 7'd34;
  localparam logic [6:0] ID_MTC1    = 7'd35;
  localparam logic [6:0] ID_CTC1    = 7'd36;
  localparam logic [6:0] ID_ADDAS   = 7'd37;
  localparam logic [6:0] ID_J       = 7'd46;
  localparam logic [6:0] ID_JAL     = 7'd47;

  // Primary opcodes that open a sub-table
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_COP1    = 6'h11;
  localparam logic [5:0] OP_MMI     = 6'h1C;

  localparam logic [4:0] COP1_MT    = 5'h04;
  localparam logic [4:0] COP1_CT    = 5'h06;
  localparam logic [4:0] COP1_S     = 5'h10;
  localparam logic [5:0] FN_ADDA    = 6'h18;
  localparam logic [5:0] FN_MTHI1   = 6'h11;
  localparam logic [5:0] FN_MTLO1   = 6'h13;
  localparam logic [5:0] FN_PADDUW  = 6'h28;
  localparam logic [4:0] SA_PADDUW  = 5'h10;

  localparam logic [3:0] JUMP_REGION_MASK = 4'hF;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] fetch_pc;
  } dec_in_t;

  typedef struct packed {
    logic [6:0]         instr_id;
    logic [2:0]         instr_class;
    logic [2:0]         mem_width;
    logic               delay_slot;
    logic               likely_flag;
    logic               link_flag;
    logic [4:0]         src_reg;
    logic [4:0]         tgt_reg;
    logic [4:0]         dst_reg;
    logic signed [15:0] signed_imm;
    logic               target_valid;
    logic [31:0]        target_addr;
  } dec_out_t;

  typedef struct packed {
    iclass_t cls;
    mwidth_t width;
    logic    likely;
    logic    link;
  } attr_t;

  function automatic attr_t mk_attr(iclass_t c, mwidth_t w, logic l, logic k);
    attr_t a;
    a.cls    = c;
    a.width  = w;
    a.likely = l;
    a.link   = k;
    return a;
  endfunction

  // Primary opcode to identity; sub-table opcodes give 0 here
  function automatic logic [6:0] op_id(logic [5:0] op);
    logic [6:0] r;
    r = ID_UNKNOWN;
    case (op) inside
      [6'h02:6'h0F]: r = 7'(op) + 7'd44;
      [6'h14:6'h1B]: r = 7'(op) + 7'd40;
      [6'h1E:6'h2E]: r = 7'(op) + 7'd38;
      6'h31:         r = 7'd85;
      6'h36:         r = 7'd86;
      6'h37:         r = 7'd87;
      6'h39:         r = 7'd88;
      6'h3E:         r = 7'd89;
      6'h3F:         r = 7'd90;
      default:       r = ID_UNKNOWN;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] special_id(logic [5:0] fn);
    logic [6:0] r;
    r = ID_UNKNOWN;
    case (fn) inside
      6'h00:         r = 7'd2;
      [6'h02:6'h04]: r = 7'(fn) + 7'd1;
      [6'h06:6'h09]: r = 7'(fn);
      6'h0C:         r = 7'd10;
      6'h0D:         r = 7'd11;
      6'h0F:         r = 7'd12;
      [6'h10:6'h13]: r = 7'(fn) - 7'd3;
      [6'h18:6'h1B]: r = 7'(fn) - 7'd4;
      [6'h20:6'h27]: r = 7'(fn) - 7'd8;
      6'h2A:         r = 7'd32;
      6'h2B:         r = 7'd33;
      default:       r = ID_UNKNOWN;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] regimm_id(logic [4:0] rt);
    logic [6:0] r;
    r = ID_UNKNOWN;
    case (rt) inside
      [5'h00:5'h03]: r = 7'(rt) + 7'd38;
      [5'h10:5'h13]: r = 7'(rt) + 7'd26;
      5'h19:         r = ID_MTSAH;
      default:       r = ID_UNKNOWN;
    endcase
    return r;
  endfunction

  function automatic attr_t id_attr(logic [6:0] id);
    attr_t a;
    a = mk_attr(CLS_NONE, MW_NONE, 1'b0, 1'b0);
    case (id) inside
      [7'd1:7'd7], [7'd12:7'd37], [7'd52:7'd59], 7'd64, 7'd65:
        a = mk_attr(CLS_ALU, MW_NONE, 1'b0, 1'b0);
      7'd8, 7'd46:        a = mk_attr(CLS_JUMP, MW_NONE, 1'b0, 1'b0);
      7'd9, 7'd47:        a = mk_attr(CLS_JUMP, MW_NONE, 1'b0, 1'b1);
      7'd10, 7'd11:       a = mk_attr(CLS_SYSTEM, MW_NONE, 1'b0, 1'b0);
      7'd38, 7'd39, [7'd48:7'd51]:
        a = mk_attr(CLS_BRANCH, MW_NONE, 1'b0, 1'b0);
      7'd40, 7'd41, [7'd60:7'd63]:
        a = mk_attr(CLS_BRANCH, MW_NONE, 1'b1, 1'b0);
      7'd42, 7'd43:       a = mk_attr(CLS_BRANCH, MW_NONE, 1'b0, 1'b1);
      7'd44, 7'd45:       a = mk_attr(CLS_BRANCH, MW_NONE, 1'b1, 1'b1);
      7'd66, 7'd67, 7'd87: a = mk_attr(CLS_LOAD, MW_DWORD, 1'b0, 1'b0);
      7'd68, 7'd86:       a = mk_attr(CLS_LOAD, MW_QWORD, 1'b0, 1'b0);
      7'd70, 7'd74:       a = mk_attr(CLS_LOAD, MW_BYTE, 1'b0, 1'b0);
      7'd71, 7'd75:       a = mk_attr(CLS_LOAD, MW_HALF, 1'b0, 1'b0);
      7'd72, 7'd73, 7'd76, 7'd77, 7'd85:
        a = mk_attr(CLS_LOAD, MW_WORD, 1'b0, 1'b0);
      7'd69, 7'd89:       a = mk_attr(CLS_STORE, MW_QWORD, 1'b0, 1'b0);
      7'd78:              a = mk_attr(CLS_STORE, MW_BYTE, 1'b0, 1'b0);
      7'd79:              a = mk_attr(CLS_STORE, MW_HALF, 1'b0, 1'b0);
      7'd80, 7'd81, 7'd84, 7'd88:
        a = mk_attr(CLS_STORE, MW_WORD, 1'b0, 1'b0);
      7'd82, 7'd83, 7'd90: a = mk_attr(CLS_STORE, MW_DWORD, 1'b0, 1'b0);
      default:            a = mk_attr(CLS_NONE, MW_NONE, 1'b0, 1'b0);
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/mipsdec_classify.sv
module mipsdec_classify (
  input  logic [31:0]          word,
  output logic [6:0]           id,
  output mipsdec_pkg::attr_t   attr
);
  import mipsdec_pkg::*;

  logic [5:0] op;
  logic [4:0] rs;
  logic [4:0] rt;
  logic [4:0] rd;
  logic [4:0] sa;
  logic [5:0] fn;
  logic [6:0] sp_id;

  assign op = word[31:26];
  assign rs = word[25:21];
  assign rt = word[20:16];
  assign rd = word[15:11];
  assign sa = word[10:6];
  assign fn = word[5:0];
  assign sp_id = special_id(fn);

  always_comb begin
    id = ID_UNKNOWN;
    case (op)
      OP_SPECIAL: begin
        if (word == 32'd0) begin
          id = ID_NOP;
        end else if (sp_id == ID_JR && (rt | rd | sa) != 5'd0) begin
          id = ID_UNKNOWN;
        end else if (sp_id == ID_JALR && (rt | sa) != 5'd0) begin
          id = ID_UNKNOWN;
        end else begin
          id = sp_id;
        end
      end
      OP_REGIMM: id = regimm_id(rt);
      OP_COP1: begin
        if (rs == COP1_MT) begin
          id = ID_MTC1;
        end else if (rs == COP1_CT) begin
          id = ID_CTC1;
        end else if (rs == COP1_S && fn == FN_ADDA) begin
          id = ID_ADDAS;
        end
      end
      OP_MMI: begin
        if (fn == FN_MTHI1) begin
          id = ID_MTHI1;
        end else if (fn == FN_MTLO1) begin
          id = ID_MTLO1;
        end else if (fn == FN_PADDUW && sa == SA_PADDUW) begin
          id = ID_PADDUW;
        end
      end
      default: id = op_id(op);
    endcase
  end

  assign attr = id_attr(id);

endmodule

FILE: rtl/mipsdec_target.sv
module mipsdec_target (
  input  logic [31:0]          word,
  input  logic [31:0]          pc,
  input  logic [6:0]           id,
  input  mipsdec_pkg::iclass_t cls,
  output logic                 valid,
  output logic [31:0]          addr
);
  import mipsdec_pkg::*;

  logic [31:0] seq_pc;
  logic [31:0] br_off;

  assign seq_pc = pc + 32'd4;
  // sign-extended word offset
  assign br_off = {{14{word[15]}}, word[15:0], 2'b00};

  always_comb begin
    valid = 1'b0;
    addr  = 32'd0;
    if (cls == CLS_BRANCH) begin
      valid = 1'b1;
      addr  = seq_pc + br_off;
    end else if (id == ID_J || id == ID_JAL) begin
      valid = 1'b1;
      addr  = {seq_pc[31:28] & JUMP_REGION_MASK, word[25:0], 2'b00};
    end
  end

endmodule

FILE: rtl/mips_instruction_decoder.sv
// MIPS-family instruction decoder. Each transaction takes one instruction
// word with its fetch address and yields one decoded result: the word and
// address are first captured in an input register, and are afterwards
// decoded by a single pass of table logic and the target adder, and held
// in a result register. busy is always low, so a new transaction may be
// started on every cycle and results leave at one per cycle. done is high
// for exactly one cycle with each result; the receiver cannot stall it and
// must take the result in that cycle. Reset clears only the valid flags.
module mips_instruction_decoder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  mipsdec_pkg::dec_in_t  instr,
  output logic                  done,
  output mipsdec_pkg::dec_out_t result
);
  import mipsdec_pkg::*;

  // input stage
  logic    in_valid;
  dec_in_t in_reg;

  // decode logic
  logic [6:0]  id;
  attr_t       attr;
  logic        tgt_valid;
  logic [31:0] tgt_addr;
  dec_out_t    result_next;

  // never back-pressured: the pipeline moves every cycle
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      in_reg <= instr;
    end
  end

  mipsdec_classify u_classify (
    .word (in_reg.instr_word),
    .id   (id),
    .attr (attr)
  );

  mipsdec_target u_target (
    .word  (in_reg.instr_word),
    .pc    (in_reg.fetch_pc),
    .id    (id),
    .cls   (attr.cls),
    .valid (tgt_valid),
    .addr  (tgt_addr)
  );

  always_comb begin
    result_next.instr_id     = id;
    result_next.instr_class  = attr.cls;
    result_next.mem_width    = attr.width;
    // both branches and jumps carry a delay slot
    result_next.delay_slot   = (attr.cls == CLS_BRANCH) || (attr.cls == CLS_JUMP);
    result_next.likely_flag  = attr.likely;
    result_next.link_flag    = attr.link;
    result_next.src_reg      = in_reg.instr_word[25:21];
    result_next.tgt_reg      = in_reg.instr_word[20:16];
    result_next.dst_reg      = in_reg.instr_word[15:11];
    result_next.signed_imm   = $signed(in_reg.instr_word[15:0]);
    result_next.target_valid = tgt_valid;
    result_next.target_addr  = tgt_addr;
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      result <= result_next;
    end
  end

  // every accepted transaction yields one result, after the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##1 done)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_valid))
    else $error("result strobe without a decoded transaction");

  a_target_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.target_valid |-> result.target_addr == 32'd0)
    else $error("target address nonzero without a direct target");

  a_likely_branch: assert property (@(posedge clk) disable iff (rst)
    done && result.likely_flag |->
      result.instr_class == CLS_BRANCH && result.target_valid)
    else $error("likely flag on a non-branch");

  a_mem_class: assert property (@(posedge clk) disable iff (rst)
    done && result.mem_width != MW_NONE |->
      result.instr_class == CLS_LOAD || result.instr_class == CLS_STORE)
    else $error("memory width on a non-memory instruction");

endmodule
